### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/scps_pkg.sv
`default_nettype none

package scps_pkg;

  typedef enum logic [2:0] {
    MsgNone      = 3'd0,
    MsgBootStart = 3'd1,
    MsgBootOk    = 3'd2,
    MsgRunStart  = 3'd3,
    MsgRunOk     = 3'd4,
    MsgReset     = 3'd5,
    MsgUnknown   = 3'd6
  } msg_e;

  // Decoded command, valid for one step when a terminator closes a command.
  typedef struct packed {
    logic boot;
    logic run;
    logic rst;
    logic unknown;
  } cmd_t;

  typedef struct packed {
    logic [7:0] strap_setup_ticks;
    logic [7:0] enable_low_ticks;
    logic [7:0] boot_settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic enable;
    logic strap;
    msg_e msg;
    logic busy;
  } seq_res_t;

  typedef struct packed {
    logic boot;
    logic run;
    logic rst;
  } kw_hit_t;

  localparam logic [7:0] MaxCommandChars = 8'd31;

  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;

  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChU = 8'h55;

  localparam logic [7:0] CfgStrapSetupReset = 8'd2;
  localparam logic [7:0] CfgEnableLowReset  = 8'd5;
  localparam logic [7:0] CfgBootSettleReset = 8'd12;

  // Which keywords have character c at position pos.
  function automatic kw_hit_t keyword_hits(input logic [2:0] pos, input logic [7:0] c);
    kw_hit_t h;
    h = '0;
    unique case (pos)
      3'd0: begin
        h.boot = (c == ChB);
        h.run  = (c == ChR);
        h.rst  = (c == ChR);
      end
      3'd1: begin
        h.boot = (c == ChO);
        h.run  = (c == ChU);
        h.rst  = (c == ChS);
      end
      3'd2: begin
        h.boot = (c == ChO);
        h.run  = (c == ChN);
        h.rst  = (c == ChT);
      end
      3'd3: begin
        h.boot = (c == ChT);
      end
      default: begin
        h = '0;
      end
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

### src/scps_parser.sv
`default_nettype none

module scps_parser import scps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output cmd_t            cmd_o
);

  logic       in_cmd_q, in_cmd_d;
  logic [2:0] count_q, count_d;
  logic       boot_q, boot_d;
  logic       run_q, run_d;
  logic       rst_q, rst_d;

  logic [7:0] upper;
  kw_hit_t    hits;
  cmd_t       cmd;

  always_comb begin
    if (byte_i >= ChLowA && byte_i <= ChLowZ) begin
      upper = byte_i - CaseOffset;
    end else begin
      upper = byte_i;
    end
    hits = keyword_hits(count_q, upper);
  end

  always_comb begin
    in_cmd_d = in_cmd_q;
    count_d  = count_q;
    boot_d   = boot_q;
    run_d    = run_q;
    rst_d    = rst_q;
    cmd      = '0;
    if (step_i) begin
      if (!in_cmd_q) begin
        if (byte_i == ChBang) begin
          in_cmd_d = 1'b1;
          count_d  = 3'd0;
          boot_d   = 1'b1;
          run_d    = 1'b1;
          rst_d    = 1'b1;
        end
      end else if (byte_i == ChCr || byte_i == ChLf) begin
        priority if (boot_q && count_q == 3'd4) begin
          cmd.boot = 1'b1;
        end else if (run_q && count_q == 3'd3) begin
          cmd.run = 1'b1;
        end else if (rst_q && count_q == 3'd3) begin
          cmd.rst = 1'b1;
        end else begin
          cmd.unknown = 1'b1;
        end
        in_cmd_d = 1'b0;
        count_d  = 3'd0;
        boot_d   = 1'b1;
        run_d    = 1'b1;
        rst_d    = 1'b1;
      end else if ({5'd0, count_q} < MaxCommandChars) begin
        boot_d = boot_q & hits.boot;
        run_d  = run_q & hits.run;
        rst_d  = rst_q & hits.rst;
        if (count_q != 3'd7) begin
          count_d = count_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cmd_q <= 1'b0;
      count_q  <= 3'd0;
      boot_q   <= 1'b1;
      run_q    <= 1'b1;
      rst_q    <= 1'b1;
    end else begin
      in_cmd_q <= in_cmd_d;
      count_q  <= count_d;
      boot_q   <= boot_d;
      run_q    <= run_d;
      rst_q    <= rst_d;
    end
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

### src/scps_seq.sv
`default_nettype none

module scps_seq import scps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tick_i,
  input  cmd_t      cmd_i,
  input  cfg_t      cfg_i,
  output logic      busy_o,
  output seq_res_t  res_o
);

  typedef enum logic [2:0] {
    PhIdle       = 3'd0,
    PhBootStrap  = 3'd1,
    PhBootEnLow  = 3'd2,
    PhBootSettle = 3'd3,
    PhRunStrap   = 3'd4,
    PhRunEnLow   = 3'd5,
    PhRstEnLow   = 3'd6
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] ticks_q, ticks_d;
  logic       en_q, en_d;
  logic       strap_q, strap_d;
  msg_e       msg;

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    en_d    = en_q;
    strap_d = strap_q;
    msg     = MsgNone;
    if (tick_i) begin
      if (phase_q != PhIdle) begin
        if (ticks_q > 8'd1) begin
          ticks_d = ticks_q - 8'd1;
        end else begin
          unique case (phase_q)
            PhBootStrap: begin
              en_d    = 1'b0;
              phase_d = PhBootEnLow;
              ticks_d = cfg_i.enable_low_ticks;
            end
            PhBootEnLow: begin
              en_d    = 1'b1;
              phase_d = PhBootSettle;
              ticks_d = cfg_i.boot_settle_ticks;
            end
            PhBootSettle: begin
              phase_d = PhIdle;
              ticks_d = 8'd0;
              msg     = MsgBootOk;
            end
            PhRunStrap: begin
              en_d    = 1'b0;
              phase_d = PhRunEnLow;
              ticks_d = cfg_i.enable_low_ticks;
            end
            PhRunEnLow: begin
              en_d    = 1'b1;
              phase_d = PhIdle;
              ticks_d = 8'd0;
              msg     = MsgRunOk;
            end
            PhIdle: begin
              phase_d = PhIdle;
            end
            default: begin
              en_d    = 1'b1;
              phase_d = PhIdle;
              ticks_d = 8'd0;
            end
          endcase
        end
      end
    end else if (cmd_i.boot) begin
      strap_d = 1'b0;
      phase_d = PhBootStrap;
      ticks_d = cfg_i.strap_setup_ticks;
      msg     = MsgBootStart;
    end else if (cmd_i.run) begin
      strap_d = 1'b1;
      phase_d = PhRunStrap;
      ticks_d = cfg_i.strap_setup_ticks;
      msg     = MsgRunStart;
    end else if (cmd_i.rst) begin
      en_d    = 1'b0;
      phase_d = PhRstEnLow;
      ticks_d = cfg_i.enable_low_ticks;
      msg     = MsgReset;
    end else if (cmd_i.unknown) begin
      msg = MsgUnknown;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ticks_q <= 8'd0;
      en_q    <= 1'b1;
      strap_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      en_q    <= en_d;
      strap_q <= strap_d;
    end
  end

  assign busy_o       = (phase_q != PhIdle);
  assign res_o.enable = en_d;
  assign res_o.strap  = strap_d;
  assign res_o.msg    = msg;
  assign res_o.busy   = (phase_d != PhIdle);

endmodule

`default_nettype wire

### src/serial_command_pin_sequencer_top.sv
`default_nettype none

// Console command sequencer for a target's enable and boot strap pins. Each input item is
// either a received byte or a 1 ms tick, and each gives exactly one result item carrying
// the pin levels, a message code and the busy and dropped flags. The block takes one item
// per clock cycle while the far side does not stall: each item is captured in the input
// register, and when it moves on the parser and sequencer state advance while the result
// is written to the output register. While the far side stalls, the output register holds
// its result, the item behind it waits in the input register, and the input channel
// stalls once that register is full.
// Configuration writes are always ready and take effect at the next wait load.
module serial_command_pin_sequencer_top import scps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       opcode_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            enable_level_o,
  output logic            strap_level_o,
  output logic [2:0]      message_o,
  output logic            busy_res_o,
  output logic            byte_dropped_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  typedef enum logic [1:0] {
    CfgStrapSetup = 2'd0,
    CfgEnableLow  = 2'd1,
    CfgBootSettle = 2'd2,
    CfgNone       = 2'd3
  } cfg_idx_e;

  logic       in_valid_q;
  logic       in_opcode_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  seq_res_t   out_res_q;
  logic       out_dropped_q;
  cfg_t       cfg_q;

  logic       accept_in;
  logic       advance;
  logic       busy;
  logic       byte_step;
  logic       tick_step;
  logic       dropped;
  cmd_t       cmd;
  seq_res_t   res;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign tick_step  = advance && in_opcode_q;
  assign byte_step  = advance && !in_opcode_q && !busy;
  assign dropped    = !in_opcode_q && busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_opcode_q <= opcode_i;
      in_byte_q   <= rx_byte_i;
    end
  end

  scps_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (byte_step),
    .byte_i (in_byte_q),
    .cmd_o  (cmd)
  );

  scps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_step),
    .cmd_i  (cmd),
    .cfg_i  (cfg_q),
    .busy_o (busy),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q     <= res;
      out_dropped_q <= dropped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strap_setup_ticks <= CfgStrapSetupReset;
      cfg_q.enable_low_ticks  <= CfgEnableLowReset;
      cfg_q.boot_settle_ticks <= CfgBootSettleReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgStrapSetup: cfg_q.strap_setup_ticks <= cfg_data_i;
        CfgEnableLow:  cfg_q.enable_low_ticks  <= cfg_data_i;
        CfgBootSettle: cfg_q.boot_settle_ticks <= cfg_data_i;
        CfgNone: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign enable_level_o = out_res_q.enable;
  assign strap_level_o  = out_res_q.strap;
  assign message_o      = out_res_q.msg;
  assign busy_res_o     = out_res_q.busy;
  assign byte_dropped_o = out_dropped_q;

endmodule

`default_nettype wire

### src/scps_checker.sv
`default_nettype none

`include "assert_macros.svh"

module scps_checker import scps_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_stall_i,
  input wire logic       enable_level_i,
  input wire logic       strap_level_i,
  input wire logic [2:0] message_i,
  input wire logic       busy_res_i,
  input wire logic       byte_dropped_i
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i && $stable(message_i) && $stable(busy_res_i), "Stalled result item changed")
  `ASSERT_CLK(a_drop_busy, clk_i, rst_ni, out_valid_i && byte_dropped_i |-> busy_res_i, "Dropped byte while not busy")
  `ASSERT_CLK(a_boot_start, clk_i, rst_ni, out_valid_i && message_i == MsgBootStart |-> !strap_level_i && busy_res_i && enable_level_i, "Boot start with wrong pins")
  `ASSERT_CLK(a_done, clk_i, rst_ni, out_valid_i && (message_i == MsgBootOk || message_i == MsgRunOk) |-> !busy_res_i && enable_level_i, "Done message while busy or enable low")

endmodule

bind serial_command_pin_sequencer_top scps_checker u_scps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .enable_level_i (enable_level_o),
  .strap_level_i  (strap_level_o),
  .message_i      (message_o),
  .busy_res_i     (busy_res_o),
  .byte_dropped_i (byte_dropped_o)
);

`default_nettype wire
